// ===== hw/rtl/bgc_pkg.sv =====
// Shared constants, types and widths for the button gesture classifier.
// No dependencies; imported by every module of the block.
package bgc_pkg;

  // Widths of the fields and registers
  localparam int THR_W   = 7;
  localparam int LIM_W   = 7;
  localparam int COUNT_W = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  // Defaults
  localparam int DEFAULT_NUM_BUTTONS = 2;
  localparam logic [THR_W-1:0] THR_RESET = 7'd5;
  localparam logic [LIM_W-1:0] LIM_RESET = 7'd125;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_LIMIT     = 1'd1;

  // Gesture codes
  localparam logic [KIND_W-1:0] KIND_PRESS          = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAP            = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOUBLE_TAP     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TAP_THEN_PRESS = 2'd3;

  // Decision of the classifier for one sample
  typedef struct packed {
    logic signed [COUNT_W-1:0] count_next;
    logic                      pending_next;
    logic                      fire;
    logic [KIND_W-1:0]         kind;
  } bgc_decision_t;

endpackage

// ===== hw/rtl/bgc_classify.sv =====
// Per-sample decision logic: next run count, next tap flag and gesture.
// Depends on bgc_pkg.
module bgc_classify import bgc_pkg::*; (
  input  logic                      pressed,
  input  logic signed [COUNT_W-1:0] count,
  input  logic                      pending,
  input  logic [THR_W-1:0]          press_threshold,
  input  logic [LIM_W-1:0]          count_limit,
  output bgc_decision_t             decision
);

  // One extra bit keeps count +/- 1 and the negated bounds in range
  logic signed [COUNT_W:0] c_ext;
  logic signed [COUNT_W:0] thr_ext;
  logic signed [COUNT_W:0] lim_ext;
  logic signed [COUNT_W:0] c_up;
  logic signed [COUNT_W:0] c_down;

  assign c_ext   = (COUNT_W+1)'(count);
  assign thr_ext = $signed({2'b00, press_threshold});
  assign lim_ext = $signed({2'b00, count_limit});

  // Restart a negative count on press, then step
  assign c_up   = ((c_ext < 0) ? '0 : c_ext) + 9'sd1;
  assign c_down = c_ext - 9'sd1;

  always_comb begin
    decision.count_next   = count;
    decision.pending_next = pending;
    decision.fire         = 1'b0;
    decision.kind         = KIND_PRESS;
    if (pressed) begin
      // Held: count up, saturate at the limit
      decision.count_next = (c_up > lim_ext) ? COUNT_W'(lim_ext) : COUNT_W'(c_up);
    end else if (c_ext > 0) begin
      // Release after a hold
      if (pending) begin
        decision.pending_next = 1'b0;
        decision.count_next   = '0;
        decision.fire         = 1'b1;
        decision.kind         = (c_ext < thr_ext) ? KIND_DOUBLE_TAP : KIND_TAP_THEN_PRESS;
      end else if (c_ext >= thr_ext) begin
        decision.count_next = '0;
        decision.fire       = 1'b1;
        decision.kind       = KIND_PRESS;
      end else begin
        decision.pending_next = 1'b1;
        decision.count_next   = -8'sd1;
      end
    end else begin
      // Continued release: count down to -limit, or fire an armed tap
      if (pending && ((c_down < -lim_ext ? -lim_ext : c_down) <= -thr_ext)) begin
        decision.pending_next = 1'b0;
        decision.count_next   = '0;
        decision.fire         = 1'b1;
        decision.kind         = KIND_TAP;
      end else begin
        decision.count_next = (c_down < -lim_ext) ? COUNT_W'(-lim_ext) : COUNT_W'(c_down);
      end
    end
  end

endmodule

// ===== hw/rtl/button_gesture_classifier_top.sv =====
// Top level of the button gesture classifier: input stage, per-button state,
// result register and configuration registers. Depends on bgc_pkg, bgc_classify.

// Each scan sample (button number, active-high level) is taken into an input
// register and classified from there in a single read-modify-write of that
// button's run count and tap flag; a gesture, if any, is loaded into the result
// register as the sample leaves the input register. The block takes one
// sample every cycle: the only limit is the result register, and a sample
// that yields a gesture waits in the input stage while an earlier result has
// not been taken. Samples for a button number at or above NUM_BUTTONS are
// dropped without effect. State is cleared at reset; there is no clearing
// pass. Configuration is always ready and should be written only while the
// block is idle.
module button_gesture_classifier_top import bgc_pkg::*; #(
  parameter int NUM_BUTTONS = DEFAULT_NUM_BUTTONS
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] button_index, [1] pressed, rest zero
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] event_button, [2:1] event_kind, rest 0
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Only buttons reachable by a one-bit number get storage
  localparam int STORE_DEPTH = (NUM_BUTTONS < 2) ? NUM_BUTTONS : 2;

  logic [THR_W-1:0] press_threshold;
  logic [LIM_W-1:0] count_limit;

  logic signed [COUNT_W-1:0] run_count [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]    tap_pending;

  logic s1_valid;
  logic s1_button;
  logic s1_pressed;

  logic          in_range;
  logic          entry;
  logic          slot_free;
  logic          s1_advance;
  logic          out_load;
  bgc_decision_t decision;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= THR_RESET;
      count_limit     <= LIM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRESS_THRESHOLD: press_threshold <= cfg_data;
        REG_COUNT_LIMIT:     count_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: take a request whenever the stage is empty or moving on
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign s1_advance    = s1_valid && (!(in_range && decision.fire) || slot_free);
  assign s_axis_tready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_button  <= s_axis_tdata[0];
      s1_pressed <= s_axis_tdata[1];
    end
  end

  // Look up the button's state
  assign in_range = (32'(s1_button) < NUM_BUTTONS);
  assign entry    = (STORE_DEPTH > 1) ? s1_button : 1'b0;

  bgc_classify u_classify (
    .pressed         (s1_pressed),
    .count           (run_count[entry]),
    .pending         (tap_pending[entry]),
    .press_threshold (press_threshold),
    .count_limit     (count_limit),
    .decision        (decision)
  );

  // Write back the button's state when the sample leaves the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        run_count[i] <= '0;
      end
      tap_pending <= '0;
    end else if (s1_advance && in_range) begin
      run_count[entry]   <= decision.count_next;
      tap_pending[entry] <= decision.pending_next;
    end
  end

  // Result register
  assign out_load = s1_advance && in_range && decision.fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{(OUT_TDATA_W-1-KIND_W){1'b0}}, decision.kind, s1_button};
    end
  end

endmodule

// ===== test/button_gesture_classifier_top_tb.sv =====
// Testbench for button_gesture_classifier_top: drives scan samples and register writes,
// predicts each gesture and checks every result in order. Depends on bgc_pkg and the RTL.
module button_gesture_classifier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bgc_pkg::*;

  localparam int NUM_BTN = DEFAULT_NUM_BUTTONS;
  // Cycles to let the input and result stages settle after the last result
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic              button;
    logic [KIND_W-1:0] kind;
  } gesture_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [0] button_index, [1] pressed
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] event_button, [2:1] event_kind
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Mirror of the block state and registers
  logic signed [COUNT_W-1:0] run_cnt [NUM_BTN];
  logic                      tap_armed [NUM_BTN];
  logic [THR_W-1:0]          press_thr;
  logic [LIM_W-1:0]          count_lim;

  gesture_t gesture_q [$];
  int err_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;

  // Per-button script of the random gesture generator
  int   script_left [NUM_BTN];
  logic script_level [NUM_BTN];

  button_gesture_classifier_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #3_000_000;
    $display("button_gesture_classifier_top: mismatch");
    $finish;
  end

  task automatic report_error(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    err_cnt++;
  endtask

  // Update the mirrored state for one sample; return 1 when a gesture fires
  function automatic bit classify_scan(input logic btn, input logic level,
                                       output logic [KIND_W-1:0] kind);
    int c;
    int thr;
    int lim;
    bit fire;
    c = run_cnt[btn];
    thr = press_thr;
    lim = count_lim;
    fire = 1'b0;
    kind = KIND_PRESS;
    if (level) begin
      if (c < 0) c = 0;
      c++;
      if (c > lim) c = lim;
    end else if (c > 0) begin
      if (tap_armed[btn]) begin
        tap_armed[btn] = 1'b0;
        kind = (c < thr) ? KIND_DOUBLE_TAP : KIND_TAP_THEN_PRESS;
        fire = 1'b1;
        c = 0;
      end else if (c >= thr) begin
        kind = KIND_PRESS;
        fire = 1'b1;
        c = 0;
      end else begin
        tap_armed[btn] = 1'b1;
        c = -1;
      end
    end else begin
      c--;
      if (c < -lim) c = -lim;
      if (tap_armed[btn] && c <= -thr) begin
        tap_armed[btn] = 1'b0;
        kind = KIND_TAP;
        fire = 1'b1;
        c = 0;
      end
    end
    run_cnt[btn] = c[COUNT_W-1:0];
    return fire;
  endfunction

  // Offer one sample, wait for the request to be taken, then maybe idle
  task automatic send_scan(input logic btn, input logic level);
    logic [KIND_W-1:0] kind;
    s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, level, btn};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (classify_scan(btn, level, kind))
      gesture_q.push_back('{button: btn, kind: kind});
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_run(input logic btn, input logic level, input int n);
    repeat (n) send_scan(btn, level);
  endtask

  // Hold the input, drain all results and let the pipeline empty
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PRESS_THRESHOLD) press_thr = val;
    else count_lim = val;
  endtask

  task automatic set_regs(input int thr, input int lim);
    write_reg(REG_PRESS_THRESHOLD, thr[CFG_DATA_W-1:0]);
    write_reg(REG_COUNT_LIMIT, lim[CFG_DATA_W-1:0]);
  endtask

  // Run length around the threshold, short runs favored
  function automatic int pick_run_len();
    int t;
    int n;
    t = press_thr;
    case ($urandom_range(5))
      0: n = 1;
      1: n = t - 1;
      2: n = t;
      3: n = t + 1;
      4: n = $urandom_range(2 * t + 2, 1);
      default: n = $urandom_range(4, 1);
    endcase
    return (n < 1) ? 1 : n;
  endfunction

  // Interleaved hold/release runs on both buttons, with some noise
  task automatic run_random(input int n_items);
    logic btn;
    logic level;
    repeat (n_items) begin
      btn = 1'($urandom_range(NUM_BTN - 1));
      if (script_left[btn] == 0) begin
        script_level[btn] = ~script_level[btn];
        script_left[btn] = pick_run_len();
      end
      script_left[btn]--;
      level = ($urandom_range(99) < 8) ? logic'($urandom_range(1)) : script_level[btn];
      send_scan(btn, level);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expected gesture
  always @(posedge clk) begin
    gesture_t exp_g;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (gesture_q.size() == 0) begin
        report_error($sformatf("unexpected result tdata=%h", m_axis_tdata));
      end else begin
        exp_g = gesture_q.pop_front();
        if (m_axis_tdata[0] !== exp_g.button)
          report_error($sformatf("event_button got %b want %b", m_axis_tdata[0], exp_g.button));
        if (m_axis_tdata[2:1] !== exp_g.kind)
          report_error($sformatf("event_kind got %0d want %0d (button %b)",
                                 m_axis_tdata[2:1], exp_g.kind, exp_g.button));
      end
    end
  end

  // Each gesture on default settings, spread over both buttons
  task automatic test_directed_gestures();
    send_run(1'b0, 1'b1, 5);   // long hold then release: press
    send_run(1'b0, 1'b0, 1);
    send_run(1'b1, 1'b1, 1);   // short hold, long gap: tap
    send_run(1'b1, 1'b0, 5);
    send_run(1'b0, 1'b1, 2);   // two short holds: double tap
    send_run(1'b0, 1'b0, 1);
    send_run(1'b0, 1'b1, 3);
    send_run(1'b0, 1'b0, 1);
    send_run(1'b1, 1'b1, 1);   // short hold then long hold: tap then press
    send_run(1'b1, 1'b0, 2);
    send_run(1'b1, 1'b1, 6);
    send_run(1'b1, 1'b0, 1);
  endtask

  task automatic test_random_defaults();
    run_random(300);
  endtask

  // Zero threshold: arm a tap first so it fires on the first released sample
  task automatic test_zero_threshold();
    set_regs(5, 3);
    send_run(1'b0, 1'b1, 1);
    send_run(1'b0, 1'b0, 1);
    set_regs(0, 3);
    send_run(1'b0, 1'b0, 1);
    send_run(1'b1, 1'b1, 4);
    send_run(1'b1, 1'b0, 2);
    run_random(110);
  endtask

  task automatic test_long_threshold();
    set_regs(127, 127);
    run_random(300);
  endtask

  // Zero limit keeps every count at zero
  task automatic test_zero_limit();
    set_regs(3, 0);
    run_random(100);
  endtask

  task automatic test_unit_settings();
    set_regs(1, 1);
    run_random(120);
  endtask

  // Long receiver hold-off while the sender keeps offering gesture-heavy samples
  task automatic test_backpressure();
    set_regs(1, 127);
    rx_hold_left = 400;
    for (int i = 0; i < 60; i++)
      send_scan(i[1], ~i[0]);
    run_random(60);
  endtask

  task automatic test_random_mixed();
    set_regs(4, 20);
    run_random(150);
    set_regs($urandom_range(12, 2), $urandom_range(127, 1));
    run_random(120);
  endtask

  initial begin
    for (int b = 0; b < NUM_BTN; b++) begin
      run_cnt[b] = '0;
      tap_armed[b] = 1'b0;
      script_left[b] = 0;
      script_level[b] = 1'b0;
    end
    press_thr = THR_RESET;
    count_lim = LIM_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 8;
    rx_idle_pct = 73;
    test_directed_gestures();
    test_random_defaults();
    test_zero_threshold();

    tx_idle_pct = 73;
    rx_idle_pct = 8;
    test_long_threshold();
    test_zero_limit();
    test_unit_settings();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random_mixed();

    wait_drained();
    if (err_cnt == 0) begin
      $display("button_gesture_classifier_top: match");
    end else begin
      $display("button_gesture_classifier_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bgc_pkg.sv
hw/rtl/bgc_classify.sv
hw/rtl/button_gesture_classifier_top.sv
test/button_gesture_classifier_top_tb.sv
